### hdl/ssm_pkg.sv
// Shared types and constants of the stripe segment mapper.
`timescale 1ns / 1ps
`default_nettype none
package ssm_pkg;

    localparam int MAX_DISKS    = 8;
    localparam int MAX_SEGMENTS = 64;

    localparam int DIV_W = 32;
    localparam int DVS_W = 17;

    localparam int QDEPTH = 2;

    localparam logic [3:0]  DISK_COUNT_RESET = 4'd2;
    localparam logic [16:0] STRIPE_RESET     = 17'd256;
    localparam logic [16:0] STRIPE_MAX       = 17'd65536;
    localparam logic [29:0] DISK_MAX         = 30'd536870912;
    localparam logic [7:0]  READY_RESET      = 8'd0;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_SEGS  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_DISK_COUNT = 2'd0,
        CFG_STRIPE     = 2'd1,
        CFG_DISK_BYTES = 2'd2,
        CFG_READY      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  disk_count;
        logic [16:0] stripe_bytes;
        logic [29:0] disk_bytes;
        logic [7:0]  ready_mask;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        t_status     status;
        logic [2:0]  disk;
        logic [28:0] off;
        logic [16:0] len;
        logic [20:0] left;
        logic [28:0] row;
        logic [16:0] sbytes;
        logic [3:0]  dcount;
    } t_job;

endpackage
`default_nettype wire

### hdl/stripe_segment_mapper.sv
// Top level of the stripe segment mapper with its configuration registers.
//
// A request (start offset, length) is taken on the input channel when
// i_in_valid and o_in_ready are high. It is split into one result per
// touched stripe unit, each with disk, offset in that disk, length and a
// last flag; a failed array, a request past the capacity or one that needs
// too many segments gives a single error result instead.
// A mapped request holds the front end from its transfer to the next through
// three divisions on the shared one-bit-per-cycle divider, the products, the
// checks and the queue push. A failed array goes from idle straight to the
// push; a range or segment error skips the third division and row product.
// With an idle back end the first result passes the queue, the back end's
// working register and the result register, then one segment follows per
// cycle while i_out_ready is high, and o_out_valid drops between requests.
// A two-entry job queue lets the front end work on the next request while
// the back end is still sending segments; a stalled receiver holds the
// result register and in turn fills the queue, after which o_in_ready stays
// low. Configuration writes are always taken and act on later requests.
// Reset clears all control state and loads the default configuration:
// two disks, 256-byte stripes, full-size disks and no disk ready.
`timescale 1ns / 1ps
`default_nettype none
module stripe_segment_mapper
    import ssm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [29:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_start_offset,
    input  wire logic [20:0] i_req_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [2:0]       o_disk_index,
    output logic [28:0]      o_disk_offset,
    output logic [16:0]      o_seg_length,
    output logic             o_last_segment
);

    t_cfg     r_cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    t_job     job_in;
    t_job     job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disk_count   <= DISK_COUNT_RESET;
            r_cfg.stripe_bytes <= STRIPE_RESET;
            r_cfg.disk_bytes   <= DISK_MAX;
            r_cfg.ready_mask   <= READY_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DISK_COUNT: r_cfg.disk_count   <= i_cfg_data[3:0];
                CFG_STRIPE:     r_cfg.stripe_bytes <= i_cfg_data[16:0];
                CFG_DISK_BYTES: r_cfg.disk_bytes   <= i_cfg_data;
                CFG_READY:      r_cfg.ready_mask   <= i_cfg_data[7:0];
                default:        r_cfg.ready_mask   <= r_cfg.ready_mask;
            endcase
        end
    end

    ssm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ssm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_offset (i_start_offset),
        .i_req_length   (i_req_length),
        .o_div_req      (div_req),
        .i_div_rsp      (div_rsp),
        .o_push         (push),
        .o_job          (job_in),
        .i_full         (full)
    );

    ssm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    ssm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (job_out),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_disk_index   (o_disk_index),
        .o_disk_offset  (o_disk_offset),
        .o_seg_length   (o_seg_length),
        .o_last_segment (o_last_segment)
    );

endmodule
`default_nettype wire

### hdl/ssm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ssm_divider
    import ssm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        ge    = (trial >= {1'b0, i_req.divisor});
        n_rem = ge ? DVS_W'(trial - {1'b0, i_req.divisor}) : trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

### hdl/ssm_front.sv
// Front end: accepts requests, checks them and works out the first segment.
`timescale 1ns / 1ps
`default_nettype none
module ssm_front
    import ssm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_start_offset,
    input  wire logic [20:0] i_req_length,
    output t_div_req         o_div_req,
    input  wire t_div_rsp    i_div_rsp,
    output logic             o_push,
    output t_job             o_job,
    input  wire logic        i_full
);

    typedef enum logic [8:0] {
        F_IDLE      = 9'b000000001,
        F_DIV_CAP   = 9'b000000010,
        F_MUL_D     = 9'b000000100,
        F_DIV_START = 9'b000001000,
        F_CHECK     = 9'b000010000,
        F_DIV_ROW   = 9'b000100000,
        F_MUL_ROW   = 9'b001000000,
        F_PUSH      = 9'b010000000,
        F_SPARE     = 9'b100000000
    } t_fstate;

    localparam logic [5:0] SEG_MUL = 6'(MAX_SEGMENTS - 1);

    t_fstate     r_state;
    t_status     r_status;
    logic [31:0] r_start;
    logic [20:0] r_len;
    logic [16:0] r_s;
    logic [3:0]  r_d;
    logic [29:0] r_prod;
    logic [33:0] r_cap;
    logic [31:0] r_slide;
    logic [16:0] r_within;
    logic [16:0] r_first;
    logic [20:0] r_rest;
    logic [31:0] r_rowq;
    logic [2:0]  r_disk;
    logic [28:0] r_row;

    logic [16:0] s_eff;
    logic [29:0] db_eff;
    logic [7:0]  need;
    logic        disk_fail;
    logic        accept;
    logic [46:0] cap_prod;
    logic [33:0] cap_mul;
    logic [48:0] row_prod;
    logic [32:0] end_sum;
    logic        oor;
    logic [16:0] head;
    logic [16:0] first;
    logic [20:0] rest;
    logic [22:0] lim;
    logic        many;

    always_comb begin
        if (i_cfg.stripe_bytes == '0) begin
            s_eff = 17'd1;
        end else if (i_cfg.stripe_bytes > STRIPE_MAX) begin
            s_eff = STRIPE_MAX;
        end else begin
            s_eff = i_cfg.stripe_bytes;
        end
        db_eff    = (i_cfg.disk_bytes > DISK_MAX) ? DISK_MAX : i_cfg.disk_bytes;
        need      = 8'((9'd1 << i_cfg.disk_count) - 9'd1);
        disk_fail = (i_cfg.disk_count < 4'd2) || (32'(i_cfg.disk_count) > MAX_DISKS)
                    || (i_cfg.disk_count > 4'd8) || ((i_cfg.ready_mask & need) != need);
        accept    = i_in_valid && (r_state == F_IDLE);

        cap_prod = {17'b0, i_div_rsp.quo[29:0]} * {30'b0, r_s};
        cap_mul  = {4'b0, r_prod} * {30'b0, r_d};
        row_prod = {17'b0, r_rowq} * {32'b0, r_s};

        end_sum = {1'b0, r_start} + {12'b0, r_len};
        oor     = ({2'b0, r_start} >= r_cap) || ({1'b0, end_sum} > r_cap);
        head    = r_s - r_within;
        first   = ({4'b0, head} > r_len) ? r_len[16:0] : head;
        rest    = r_len - {4'b0, first};
        lim     = {6'b0, r_s} * {17'b0, SEG_MUL};
        many    = ({2'b0, rest} > lim);
    end

    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = {2'b0, db_eff};
        o_div_req.divisor  = s_eff;
        unique case (r_state)
            F_IDLE: begin
                o_div_req.start = accept && !disk_fail;
            end
            F_MUL_D: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = r_start;
                o_div_req.divisor  = r_s;
            end
            F_DIV_START: begin
                o_div_req.dividend = r_start;
                o_div_req.divisor  = r_s;
            end
            F_CHECK: begin
                o_div_req.start    = !oor && !many;
                o_div_req.dividend = r_slide;
                o_div_req.divisor  = {13'b0, r_d};
            end
            F_DIV_ROW: begin
                o_div_req.dividend = r_slide;
                o_div_req.divisor  = {13'b0, r_d};
            end
            F_DIV_CAP, F_MUL_ROW, F_PUSH, F_SPARE: begin
                o_div_req.divisor = r_s;
            end
            default: begin
                o_div_req.divisor = r_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= disk_fail ? F_PUSH : F_DIV_CAP;
                    end
                end
                F_DIV_CAP: begin
                    if (i_div_rsp.done) begin
                        r_state <= F_MUL_D;
                    end
                end
                F_MUL_D: begin
                    r_state <= F_DIV_START;
                end
                F_DIV_START: begin
                    if (i_div_rsp.done) begin
                        r_state <= F_CHECK;
                    end
                end
                F_CHECK: begin
                    r_state <= (oor || many) ? F_PUSH : F_DIV_ROW;
                end
                F_DIV_ROW: begin
                    if (i_div_rsp.done) begin
                        r_state <= F_MUL_ROW;
                    end
                end
                F_MUL_ROW: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                F_SPARE: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start  <= i_start_offset;
            r_len    <= i_req_length;
            r_s      <= s_eff;
            r_d      <= i_cfg.disk_count;
            r_status <= disk_fail ? ST_FAIL : ST_OK;
        end
        if (r_state == F_DIV_CAP && i_div_rsp.done) begin
            r_prod <= cap_prod[29:0];
        end
        if (r_state == F_MUL_D) begin
            r_cap <= cap_mul;
        end
        if (r_state == F_DIV_START && i_div_rsp.done) begin
            r_slide  <= i_div_rsp.quo;
            r_within <= i_div_rsp.rem;
        end
        if (r_state == F_CHECK) begin
            r_first <= first;
            r_rest  <= rest;
            if (oor) begin
                r_status <= ST_RANGE;
            end else if (many) begin
                r_status <= ST_SEGS;
            end
        end
        if (r_state == F_DIV_ROW && i_div_rsp.done) begin
            r_rowq <= i_div_rsp.quo;
            r_disk <= i_div_rsp.rem[2:0];
        end
        if (r_state == F_MUL_ROW) begin
            r_row <= row_prod[28:0];
        end
    end

    always_comb begin
        o_in_ready   = (r_state == F_IDLE);
        o_push       = (r_state == F_PUSH) && !i_full;
        o_job.status = r_status;
        o_job.sbytes = r_s;
        o_job.dcount = r_d;
        if (r_status == ST_OK) begin
            o_job.disk = r_disk;
            o_job.off  = r_row + {12'b0, r_within};
            o_job.len  = r_first;
            o_job.left = r_rest;
            o_job.row  = r_row;
        end else begin
            o_job.disk = '0;
            o_job.off  = '0;
            o_job.len  = '0;
            o_job.left = '0;
            o_job.row  = '0;
        end
    end

endmodule
`default_nettype wire

### hdl/ssm_queue.sv
// Short job queue between the front end and the segment generator.
`timescale 1ns / 1ps
`default_nettype none
module ssm_queue
    import ssm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

### hdl/ssm_back.sv
// Back end: steps through the stripes of one job and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module ssm_back
    import ssm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_job  i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [1:0] o_status,
    output logic [2:0] o_disk_index,
    output logic [28:0] o_disk_offset,
    output logic [16:0] o_seg_length,
    output logic       o_last_segment
);

    logic        r_busy;
    t_job        r_w;
    logic        r_ov;
    logic [1:0]  r_status;
    logic [2:0]  r_disk;
    logic [28:0] r_off;
    logic [16:0] r_len;
    logic        r_last;

    logic        emit;
    logic        last;
    logic [16:0] piece;
    logic [3:0]  disk_inc;
    logic        wrap;
    logic [28:0] row_next;

    always_comb begin
        o_pop    = !r_busy && !i_empty;
        emit     = r_busy && (!r_ov || i_out_ready);
        last     = (r_w.left == '0);
        piece    = (r_w.left < {4'b0, r_w.sbytes}) ? r_w.left[16:0] : r_w.sbytes;
        disk_inc = {1'b0, r_w.disk} + 4'd1;
        wrap     = (disk_inc >= r_w.dcount);
        row_next = wrap ? (r_w.row + {12'b0, r_w.sbytes}) : r_w.row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_w <= i_job;
        end else if (emit) begin
            r_w.disk <= wrap ? 3'd0 : disk_inc[2:0];
            r_w.row  <= row_next;
            r_w.off  <= row_next;
            r_w.len  <= piece;
            r_w.left <= r_w.left - {4'b0, piece};
        end
        if (emit) begin
            r_status <= r_w.status;
            r_disk   <= r_w.disk;
            r_off    <= r_w.off;
            r_len    <= r_w.len;
            r_last   <= last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_status;
    assign o_disk_index   = r_disk;
    assign o_disk_offset  = r_off;
    assign o_seg_length   = r_len;
    assign o_last_segment = r_last;

endmodule
`default_nettype wire
